// ----- rtl/tked_pkg.sv -----
// Shared types and key-code constants for the terminal key escape decoder.
package tked_pkg;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_ESC   = 4'd1,
		ST_CSI   = 4'd2,
		ST_TILDE = 4'd3,
		ST_CSI2  = 4'd4,
		ST_CSI1  = 4'd5,
		ST_MOD   = 4'd6,
		ST_FINAL = 4'd7,
		ST_SS3   = 4'd8
	} parse_state_t;

	localparam int unsigned KeyW = 15;
	typedef logic [KeyW-1:0] key_t;

	localparam logic [7:0] BYTE_ESC = 8'h1B;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;

	localparam key_t KEY_NONE      = 15'h0000;
	localparam key_t KEY_ESC       = 15'h001B;
	localparam key_t KEY_UP        = 15'h0055;
	localparam key_t KEY_DOWN      = 15'h0044;
	localparam key_t KEY_RIGHT     = 15'h0052;
	localparam key_t KEY_LEFT      = 15'h004C;
	localparam key_t KEY_HOME      = 15'h01F5;
	localparam key_t KEY_END       = 15'h01F6;
	localparam key_t KEY_BOF       = 15'h01F7;
	localparam key_t KEY_EOF       = 15'h01F8;
	localparam key_t KEY_PGUP      = 15'h01F9;
	localparam key_t KEY_PGDN      = 15'h01FA;
	localparam key_t KEY_DELETE    = 15'h7F7F;
	localparam key_t KEY_F1        = 15'h00F1;
	localparam key_t KEY_F2        = 15'h00F2;
	localparam key_t KEY_F3        = 15'h00F3;
	localparam key_t KEY_F4        = 15'h00F4;
	localparam key_t KEY_F7        = 15'h00F7;
	localparam key_t KEY_F8        = 15'h00F8;
	localparam key_t KEY_F10       = 15'h0F10;
	localparam key_t KEY_SH_LEFT   = 15'h0F11;
	localparam key_t KEY_SH_RIGHT  = 15'h0F12;
	localparam key_t KEY_SH_UP     = 15'h0F13;
	localparam key_t KEY_SH_DOWN   = 15'h0F14;

endpackage

// ----- rtl/terminal_key_escape_decoder_core.sv -----
// Terminal key escape decoder: byte input register, decode state, key result register.
//
// Usage:
//   Input channel (byte_valid / byte_stall, in_byte, gap) carries one request per
//   received terminal byte, or a gap request (gap = 1) when the receive timeout
//   fires with nothing pending. Output channel (key_valid / key_stall, key_code)
//   carries decoded keys. A request yields zero or one key.
//   Path: a taken request sits in the byte input register while the decode step
//   computes its key, which loads the key register when the step advances.
//   Throughput: one request per cycle while the output is not stalled, set by the
//   single decode step between the input register and the key register; the parse
//   state updates in that same step so consecutive bytes follow without a bubble.
//   Stall: while key_stall holds a key, the decode step waits and byte_stall
//   rises once the input register is also occupied; nothing is dropped.
//   Reset: arst_n clears the parse state, the pending code, the modifier byte
//   and both valid flags; the block takes requests as soon as reset is released.
module terminal_key_escape_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         in_byte,
	input  logic               gap,
	output logic               key_valid,
	input  logic               key_stall,
	output tked_pkg::key_t     key_code
);
	import tked_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         gap_s1;
	logic         adv;

	parse_state_t state_q, state_d;
	key_t         pend_q, pend_d;
	logic [7:0]   mod_q, mod_d;
	logic         emit;
	key_t         code;

	assign adv        = valid_s1 && (!key_valid || !key_stall);
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			byte_s1 <= in_byte;
			gap_s1  <= gap;
		end
	end

	always_comb begin
		state_d = ST_IDLE;
		pend_d  = pend_q;
		mod_d   = mod_q;
		emit    = 1'b1;
		code    = KEY_NONE;
		if (gap_s1) begin
			// a gap only matters right after ESC
			if (state_q == ST_ESC) begin
				code = KEY_ESC;
			end else begin
				state_d = state_q;
				emit    = 1'b0;
			end
		end else begin
			case (state_q)
				ST_ESC: begin
					case (byte_s1)
						"b": code = KEY_HOME;
						"l": code = KEY_END;
						"h": code = KEY_BOF;
						"e": code = KEY_EOF;
						"[": begin state_d = ST_CSI; emit = 1'b0; end
						"O": begin state_d = ST_SS3; emit = 1'b0; end
						default: code = KEY_NONE;
					endcase
				end
				ST_CSI: begin
					case (byte_s1)
						"A": code = KEY_UP;
						"B": code = KEY_DOWN;
						"C": code = KEY_RIGHT;
						"D": code = KEY_LEFT;
						"H": code = KEY_HOME;
						"F": code = KEY_END;
						"5": begin state_d = ST_TILDE; pend_d = KEY_PGUP;   emit = 1'b0; end
						"6": begin state_d = ST_TILDE; pend_d = KEY_PGDN;   emit = 1'b0; end
						"3": begin state_d = ST_TILDE; pend_d = KEY_DELETE; emit = 1'b0; end
						"2": begin state_d = ST_CSI2; emit = 1'b0; end
						"1": begin state_d = ST_CSI1; emit = 1'b0; end
						default: code = KEY_NONE;
					endcase
				end
				ST_TILDE: begin
					code = (byte_s1 == "~") ? pend_q : KEY_NONE;
				end
				ST_CSI2: begin
					if (byte_s1 == "1") begin
						state_d = ST_TILDE;
						pend_d  = KEY_F10;
						emit    = 1'b0;
					end
				end
				ST_CSI1: begin
					case (byte_s1)
						"0": begin state_d = ST_TILDE; pend_d = KEY_F10; emit = 1'b0; end
						"1": begin state_d = ST_TILDE; pend_d = KEY_F1;  emit = 1'b0; end
						"2": begin state_d = ST_TILDE; pend_d = KEY_F2;  emit = 1'b0; end
						"8": begin state_d = ST_TILDE; pend_d = KEY_F7;  emit = 1'b0; end
						";": begin state_d = ST_MOD; emit = 1'b0; end
						default: code = KEY_NONE;
					endcase
				end
				ST_MOD: begin
					// take any modifier byte, check it with the final byte
					mod_d   = byte_s1;
					state_d = ST_FINAL;
					emit    = 1'b0;
				end
				ST_FINAL: begin
					if (mod_q == "2") begin
						case (byte_s1)
							"A": code = KEY_SH_UP;
							"B": code = KEY_SH_DOWN;
							"C": code = KEY_SH_RIGHT;
							"D": code = KEY_SH_LEFT;
							default: code = KEY_NONE;
						endcase
					end else if (mod_q == "3") begin
						if (byte_s1 == "H") begin
							code = KEY_F7;
						end else if (byte_s1 == "F") begin
							code = KEY_F8;
						end
					end
				end
				ST_SS3: begin
					case (byte_s1)
						"P": code = KEY_F1;
						"Q": code = KEY_F2;
						"R": code = KEY_F3;
						"S": code = KEY_F4;
						default: code = KEY_NONE;
					endcase
				end
				default: begin
					if (byte_s1 == BYTE_ESC) begin
						state_d = ST_ESC;
						emit    = 1'b0;
					end else if (byte_s1 == BYTE_CR) begin
						code = {{(KeyW-8){1'b0}}, BYTE_LF};
					end else begin
						code = {{(KeyW-8){1'b0}}, byte_s1};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= KEY_NONE;
			mod_q   <= 8'h00;
		end else if (adv) begin
			state_q <= state_d;
			pend_q  <= pend_d;
			mod_q   <= mod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
		end else if (adv) begin
			key_valid <= emit;
		end else if (!key_stall) begin
			key_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_code <= code;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("byte_stall raised with an empty input register");

	a_key_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_valid) |-> $past(valid_s1))
		else $error("key appeared without a decoded request");

	a_final_after_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |-> $past(state_q == ST_MOD || state_q == ST_FINAL))
		else $error("final state entered without a modifier byte");

	a_tilde_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TILDE) |-> (pend_q != KEY_NONE))
		else $error("waiting for tilde with no pending code");
`endif

endmodule

// ----- test/tb_terminal_key_escape_decoder_core.sv -----
// Self-checking testbench for the terminal key escape decoder core.
module tb_terminal_key_escape_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tked_pkg::*;

	typedef struct {
		logic [7:0]  b;
		logic        g;
		int unsigned hold;
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] in_byte = 8'h00;
	logic       gap = 1'b0;
	logic       key_valid;
	logic       key_stall = 1'b0;
	key_t       key_code;

	terminal_key_escape_decoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.gap        (gap),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_code   (key_code)
	);

	always #5 clk = ~clk;

	byte_req_t    byte_queue[$];
	key_t         expected_keys[$];
	int unsigned  fails = 0;
	int unsigned  sent_bytes = 0;
	bit           in_burst = 1'b0;
	bit           out_burst = 1'b0;

	// decoder state mirror
	parse_state_t dec_state = ST_IDLE;
	key_t         dec_pending = KEY_NONE;
	logic [7:0]   dec_modifier = 8'h00;

	function automatic logic decode_key(input logic [7:0] b, input logic g,
			output key_t code);
		parse_state_t st;
		st = dec_state;
		code = KEY_NONE;
		if (g) begin
			if (st == ST_ESC) begin
				dec_state = ST_IDLE;
				code = KEY_ESC;
				return 1'b1;
			end
			return 1'b0;
		end
		dec_state = ST_IDLE;
		case (st)
			ST_ESC: begin
				case (b)
					"b": code = KEY_HOME;
					"l": code = KEY_END;
					"h": code = KEY_BOF;
					"e": code = KEY_EOF;
					"[": begin dec_state = ST_CSI; return 1'b0; end
					"O": begin dec_state = ST_SS3; return 1'b0; end
					default: ;
				endcase
				return 1'b1;
			end
			ST_CSI: begin
				case (b)
					"A": code = KEY_UP;
					"B": code = KEY_DOWN;
					"C": code = KEY_RIGHT;
					"D": code = KEY_LEFT;
					"H": code = KEY_HOME;
					"F": code = KEY_END;
					"5": begin dec_pending = KEY_PGUP; dec_state = ST_TILDE; return 1'b0; end
					"6": begin dec_pending = KEY_PGDN; dec_state = ST_TILDE; return 1'b0; end
					"3": begin dec_pending = KEY_DELETE; dec_state = ST_TILDE; return 1'b0; end
					"2": begin dec_state = ST_CSI2; return 1'b0; end
					"1": begin dec_state = ST_CSI1; return 1'b0; end
					default: ;
				endcase
				return 1'b1;
			end
			ST_TILDE: begin
				if (b == "~")
					code = dec_pending;
				return 1'b1;
			end
			ST_CSI2: begin
				if (b == "1") begin
					dec_pending = KEY_F10;
					dec_state = ST_TILDE;
					return 1'b0;
				end
				return 1'b1;
			end
			ST_CSI1: begin
				case (b)
					"0": begin dec_pending = KEY_F10; dec_state = ST_TILDE; return 1'b0; end
					"1": begin dec_pending = KEY_F1; dec_state = ST_TILDE; return 1'b0; end
					"2": begin dec_pending = KEY_F2; dec_state = ST_TILDE; return 1'b0; end
					"8": begin dec_pending = KEY_F7; dec_state = ST_TILDE; return 1'b0; end
					";": begin dec_state = ST_MOD; return 1'b0; end
					default: ;
				endcase
				return 1'b1;
			end
			ST_MOD: begin
				// consume the modifier whatever it is; the pair is checked on the next byte
				dec_modifier = b;
				dec_state = ST_FINAL;
				return 1'b0;
			end
			ST_FINAL: begin
				if (dec_modifier == "2") begin
					case (b)
						"A": code = KEY_SH_UP;
						"B": code = KEY_SH_DOWN;
						"C": code = KEY_SH_RIGHT;
						"D": code = KEY_SH_LEFT;
						default: ;
					endcase
				end else if (dec_modifier == "3") begin
					if (b == "H")
						code = KEY_F7;
					else if (b == "F")
						code = KEY_F8;
				end
				return 1'b1;
			end
			ST_SS3: begin
				case (b)
					"P": code = KEY_F1;
					"Q": code = KEY_F2;
					"R": code = KEY_F3;
					"S": code = KEY_F4;
					default: ;
				endcase
				return 1'b1;
			end
			default: begin
				if (b == BYTE_ESC) begin
					dec_state = ST_ESC;
					return 1'b0;
				end
				code = (b == BYTE_CR) ? key_t'(BYTE_LF) : key_t'(b);
				return 1'b1;
			end
		endcase
	endfunction

	// driver: present queued requests, each after its own hold-off
	byte_req_t   cur_req;
	int unsigned send_idle = 0;
	key_t        new_key;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			in_byte <= 8'h00;
			gap <= 1'b0;
			send_idle <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (decode_key(in_byte, gap, new_key))
					expected_keys.push_back(new_key);
			end
			if (!byte_valid || !byte_stall) begin
				if (byte_queue.size() > 0 && send_idle >= byte_queue[0].hold) begin
					cur_req = byte_queue.pop_front();
					in_byte <= cur_req.b;
					gap <= cur_req.g;
					byte_valid <= 1'b1;
					send_idle <= 0;
				end else begin
					byte_valid <= 1'b0;
					if (byte_queue.size() > 0)
						send_idle <= send_idle + 1;
				end
			end
		end
	end

	// monitor: stall at random, compare each key with the oldest prediction
	int unsigned stall_left = 0;
	int unsigned stall_draw;
	key_t        want_key;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_stall <= 1'b0;
			stall_left <= 0;
		end else if (key_valid && !key_stall) begin
			if (expected_keys.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected key: got %h, nothing predicted", key_code);
			end else begin
				want_key = expected_keys.pop_front();
				if (key_code !== want_key) begin
					fails++;
					if (fails <= 10)
						$display("key mismatch: expected %h, got %h", want_key, key_code);
				end
			end
			if ($urandom_range(0, 24) == 0)
				out_burst = ~out_burst;
			stall_draw = out_burst ? 0 : $urandom_range(0, 10);
			stall_left <= stall_draw;
			key_stall <= (stall_draw > 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			key_stall <= (stall_left > 1);
		end
	end

	function automatic void push_req(input logic [7:0] b, input logic g);
		byte_req_t r;
		r.b = b;
		r.g = g;
		r.hold = in_burst ? 0 : $urandom_range(0, 10);
		byte_queue.push_back(r);
		sent_bytes++;
	endfunction

	// push a sequence tail, with the odd gap dropped in past its first byte
	function automatic void push_text(input string s, input bit with_gaps);
		for (int i = 0; i < s.len(); i++) begin
			if (with_gaps && i > 0 && $urandom_range(0, 9) == 0)
				push_req(8'($urandom), 1'b1);
			push_req(s[i], 1'b0);
		end
	endfunction

	string seq_tab [28] = '{
		"b", "l", "h", "e", "[A", "[B", "[C", "[D", "[H", "[F",
		"[5~", "[6~", "[3~", "[21~", "[10~", "[11~", "[12~", "[18~",
		"[1;2A", "[1;2B", "[1;2C", "[1;2D", "[1;3H", "[1;3F",
		"OP", "OQ", "OR", "OS"
	};

	string       pick;
	int unsigned sel;
	int unsigned cut;
	string       mods = "23x";
	string       finals = "ABCDHF";

	initial begin
		// directed: field extremes, carriage return, lone ESC, ignored gaps
		push_req(8'h00, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req(BYTE_CR, 1'b0);
		push_req(8'hFF, 1'b1);
		push_req(BYTE_ESC, 1'b0);
		push_req(8'h00, 1'b1);
		push_req(BYTE_ESC, 1'b0);
		push_text("[A", 1'b0);
		push_req(BYTE_ESC, 1'b0);
		push_text("[5", 1'b0);
		push_req(8'hA5, 1'b1);
		push_text("~", 1'b0);
		push_req(BYTE_ESC, 1'b0);
		push_text("[1;2A", 1'b0);
		push_req(BYTE_ESC, 1'b0);
		push_text("OP", 1'b0);
		push_req(BYTE_ESC, 1'b0);
		push_text("x", 1'b0);

		// random: mostly well-formed sequences, mixed with noise and broken ones
		while (sent_bytes < 950) begin
			if ($urandom_range(0, 29) == 0)
				in_burst = ~in_burst;
			sel = $urandom_range(0, 99);
			pick = seq_tab[$urandom_range(0, 27)];
			if (sel < 55) begin
				push_req(BYTE_ESC, 1'b0);
				push_text(pick, 1'b1);
			end else if (sel < 62) begin
				push_req(BYTE_ESC, 1'b0);
				push_req(8'($urandom), 1'b1);
			end else if (sel < 72) begin
				push_req(BYTE_ESC, 1'b0);
				push_text("[1;", 1'b1);
				push_req(($urandom_range(0, 3) == 0) ? 8'($urandom)
					: mods[$urandom_range(0, 1)], 1'b0);
				push_req(($urandom_range(0, 3) == 0) ? 8'($urandom)
					: finals[$urandom_range(0, 5)], 1'b0);
			end else if (sel < 82) begin
				cut = $urandom_range(0, pick.len() - 1);
				push_req(BYTE_ESC, 1'b0);
				push_text(pick.substr(0, int'(cut) - 1), 1'b1);
				push_req(8'($urandom), 1'b0);
			end else if (sel < 95) begin
				push_req(8'($urandom), 1'b0);
			end else begin
				push_req(8'($urandom), 1'b1);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then allow the two-stage pipe to settle
		while (byte_queue.size() > 0 || byte_valid || expected_keys.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0 && expected_keys.size() == 0)
			$display("tb_terminal_key_escape_decoder_core: done, clean");
		else
			$display("tb_terminal_key_escape_decoder_core: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_terminal_key_escape_decoder_core: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tked_pkg.sv
rtl/terminal_key_escape_decoder_core.sv
test/tb_terminal_key_escape_decoder_core.sv
